// ===== rtl/xcfd_pkg.sv =====
// shared types and codes for the xor-checked frame deframer
package xcfd_pkg;

    // event codes carried with every result
    typedef enum logic [3:0] {
        EV_IGNORED    = 4'd0,
        EV_HEADER     = 4'd1,
        EV_LENGTH_OK  = 4'd2,
        EV_PAYLOAD    = 4'd3,
        EV_CHECK_OK   = 4'd4,
        EV_FRAME_GOOD = 4'd5,
        EV_LENGTH_ERR = 4'd6,
        EV_CHECK_ERR  = 4'd7,
        EV_TAIL_ERR   = 4'd8
    } t_event;

    // configuration register indexes
    localparam logic [1:0] CFG_HEADER  = 2'd0;
    localparam logic [1:0] CFG_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_TAIL    = 2'd2;
    localparam logic [1:0] CFG_PAYLEN  = 2'd3;

    localparam logic [6:0] PAYLEN_RESET = 7'd8;

    // entries of the queue between front and back
    localparam int Q_DEPTH = 2;

    // one classified request
    typedef struct packed {
        t_event      ev;
        logic [7:0]  pbyte;
        logic [5:0]  pindex;
        logic        plast;
    } t_item;

endpackage

// ===== rtl/xcfd_front.sv =====
// front end: config registers, frame phase machine, byte classification
module xcfd_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_full,
    output logic             o_push,
    output xcfd_pkg::t_item  o_item
);
    import xcfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX8 = 8'(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_LENGTH  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_CHECK   = 5'b01000,
        PH_TAIL    = 5'b10000
    } t_phase;

    logic [7:0]       r_hdr;
    logic [7:0]       r_len;
    logic [7:0]       r_tail;
    logic [6:0]       r_plen;
    t_phase           r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_xor, n_xor;

    logic [7:0] len_ext;
    logic [7:0] eff_len;
    logic [7:0] count_ext;
    logic [7:0] count_inc;
    logic       accept;

    assign accept = i_valid && !i_full;
    assign o_push = accept;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= 8'd0;
            r_len  <= 8'd0;
            r_tail <= 8'd0;
            r_plen <= PAYLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER: r_hdr  <= i_cfg_data;
                CFG_LENGTH: r_len  <= i_cfg_data;
                CFG_TAIL:   r_tail <= i_cfg_data;
                CFG_PAYLEN: r_plen <= i_cfg_data[6:0];
            endcase
        end
    end

    // zero acts as one, oversize clamps to the maximum
    assign len_ext   = 8'(r_plen);
    assign eff_len   = (len_ext == 8'd0) ? 8'd1 : ((len_ext > MAX8) ? MAX8 : len_ext);
    assign count_ext = 8'(r_count);
    assign count_inc = count_ext + 8'd1;

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_xor         = r_xor;
        o_item.ev     = EV_IGNORED;
        o_item.pbyte  = 8'd0;
        o_item.pindex = 6'd0;
        o_item.plast  = 1'b0;
        unique case (r_phase)
            PH_HEADER: begin
                if (i_rx_byte == r_hdr) begin
                    n_count   = '0;
                    n_phase   = PH_LENGTH;
                    o_item.ev = EV_HEADER;
                end
            end
            PH_LENGTH: begin
                if (i_rx_byte == r_len) begin
                    n_count   = '0;
                    n_xor     = 8'd0;
                    n_phase   = PH_PAYLOAD;
                    o_item.ev = EV_LENGTH_OK;
                end else begin
                    // a header byte here restarts the frame
                    if (i_rx_byte != r_hdr) begin
                        n_phase = PH_HEADER;
                        n_count = '0;
                        n_xor   = 8'd0;
                    end
                    o_item.ev = EV_LENGTH_ERR;
                end
            end
            PH_PAYLOAD: begin
                o_item.ev     = EV_PAYLOAD;
                o_item.pbyte  = i_rx_byte;
                o_item.pindex = count_ext[5:0];
                n_xor         = r_xor ^ i_rx_byte;
                n_count       = CNT_W'(count_inc);
                if (count_inc >= eff_len) begin
                    o_item.plast = 1'b1;
                    n_phase      = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (i_rx_byte == r_xor) begin
                    n_phase   = PH_TAIL;
                    o_item.ev = EV_CHECK_OK;
                end else begin
                    n_phase   = PH_HEADER;
                    n_count   = '0;
                    n_xor     = 8'd0;
                    o_item.ev = EV_CHECK_ERR;
                end
            end
            PH_TAIL: begin
                o_item.ev = (i_rx_byte == r_tail) ? EV_FRAME_GOOD : EV_TAIL_ERR;
                n_phase   = PH_HEADER;
                n_count   = '0;
                n_xor     = 8'd0;
            end
            default: begin
                n_phase = PH_HEADER;
                n_count = '0;
                n_xor   = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_count <= '0;
            r_xor   <= 8'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_xor   <= n_xor;
        end
    end

`ifndef SYNTHESIS
    a_last_goes_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && o_item.ev == EV_PAYLOAD && o_item.plast |=> r_phase == PH_CHECK)
        else $error("last payload byte did not move to checksum phase");
`endif

endmodule

// ===== rtl/xcfd_queue.sv =====
// short fifo of classified requests between front and back
module xcfd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  xcfd_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output xcfd_pkg::t_item  o_item
);
    import xcfd_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item            r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/xcfd_back.sv =====
// back end: running counters and output register
module xcfd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  xcfd_pkg::t_item  i_item,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output xcfd_pkg::t_item  o_item,
    output logic [31:0]      o_parse_errors,
    output logic [31:0]      o_checksum_errors,
    output logic [31:0]      o_good_frames
);
    import xcfd_pkg::*;

    logic        r_out_valid;
    t_item       r_item;
    logic [31:0] r_parse_total;
    logic [31:0] r_check_total;
    logic [31:0] r_frame_total;

    // output slot frees when empty or taken this cycle
    assign o_pop = i_q_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_parse_total <= 32'd0;
            r_check_total <= 32'd0;
            r_frame_total <= 32'd0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                case (i_item.ev) inside
                    EV_LENGTH_ERR, EV_TAIL_ERR: r_parse_total <= r_parse_total + 32'd1;
                    EV_CHECK_ERR:               r_check_total <= r_check_total + 32'd1;
                    EV_FRAME_GOOD:              r_frame_total <= r_frame_total + 32'd1;
                    default: ;
                endcase
            end
        end
    end

    // counters only move when a result is loaded, so they match the held result
    assign o_out_valid       = r_out_valid;
    assign o_item            = r_item;
    assign o_parse_errors    = r_parse_total;
    assign o_checksum_errors = r_check_total;
    assign o_good_frames     = r_frame_total;

`ifndef SYNTHESIS
    a_counts_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_parse_total) && $stable(r_check_total) && $stable(r_frame_total))
        else $error("counter moved without a loaded result");
    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_item.ev == EV_FRAME_GOOD |=> r_frame_total == $past(r_frame_total) + 32'd1)
        else $error("good frame not counted");
`endif

endmodule

// ===== rtl/xor_checked_frame_deframer_core.sv =====
// top level of the xor-checked frame deframer
//
// channel  direction  handshake                    payload
// -------  ---------  ---------------------------  ---------------------------------
// in       receive    i_in_valid / o_in_stall      i_rx_byte
// out      send       o_out_valid / i_out_stall    o_event_res .. o_good_frames
// cfg      receive    i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// one request per cycle while the output does not stall; a result is offered once its
// request is taken (classified into the queue, then loaded into the output register)
// synchronous active-low reset clears the phase machine, queue, counters and the
// config registers (payload length resets to 8)
// o_in_stall is the queue-full flag; at full rate the queue holds one entry, so it
// rises after the output stalls and falls the cycle after the output is taken
module xor_checked_frame_deframer_core #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [5:0]  o_payload_index,
    output logic        o_last_payload,
    output logic [31:0] o_parse_errors,
    output logic [31:0] o_checksum_errors,
    output logic [31:0] o_good_frames
);
    import xcfd_pkg::*;

    logic  push;
    logic  pop;
    logic  q_valid;
    logic  q_full;
    t_item front_item;
    t_item q_item;
    t_item out_item;

    // front classifies each byte as it arrives
    xcfd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .i_full      (q_full),
        .o_push      (push),
        .o_item      (front_item)
    );

    // decouples front from output stalls
    xcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    // back updates counters and holds the result
    xcfd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_item            (q_item),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_item            (out_item),
        .o_parse_errors    (o_parse_errors),
        .o_checksum_errors (o_checksum_errors),
        .o_good_frames     (o_good_frames)
    );

    assign o_in_stall      = q_full;
    assign o_event_res     = out_item.ev;
    assign o_payload_byte  = out_item.pbyte;
    assign o_payload_index = out_item.pindex;
    assign o_last_payload  = out_item.plast;

endmodule
